>>> sv/tdq_pkg.sv
`timescale 1ns / 1ps

package tdq_pkg;

	// field widths of the request and result words
	localparam int ACTION_W = 2;
	localparam int CH_W = 8;
	localparam int ADDR_W = 32;
	localparam int LEN_W = 16;
	localparam int CNT_W = 6;
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	// launch bitmap
	localparam int BITMAP_BITS = 32;
	localparam int BIT_IDX_W = $clog2(BITMAP_BITS);

	// default queue depth
	localparam int QUEUE_DEPTH_DEF = 32;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_COMPLETE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ_CLEAR = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CH_W-1:0] req_channel;
		logic [ADDR_W-1:0] req_address;
		logic [LEN_W-1:0] req_length;
	} req_word_t;

	typedef struct packed {
		logic launched;
		logic [CH_W-1:0] launch_channel;
		logic [ADDR_W-1:0] launch_address;
		logic [LEN_W-1:0] launch_length;
		logic dropped;
		logic engine_busy;
		logic [CNT_W-1:0] waiting_count;
		logic [BITMAP_BITS-1:0] bitmap_value;
	} rsp_word_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0] length;
	} desc_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_out;
		logic launch_new;
		logic launch_queued;
		logic push;
		logic drop;
		logic go_idle;
		logic clear_bitmap;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;
		logic full;
		logic empty;
		logic [ACTION_W-1:0] action;
	} dp_status_t;

endpackage

>>> sv/tdq_chan_if.sv
`timescale 1ns / 1ps

interface tdq_chan_if #(
	parameter type word_t = logic
);
	logic valid;
	logic ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/tdq_ctrl.sv
`timescale 1ns / 1ps

module tdq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input tdq_pkg::dp_status_t status,
	output tdq_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		if (state_q == ST_EXEC) begin
			cmd.load_out = 1'b1;
			unique case (status.action)
				tdq_pkg::ACT_ENQUEUE: begin
					if (!status.busy) cmd.launch_new = 1'b1;
					else if (status.full) cmd.drop = 1'b1;
					else cmd.push = 1'b1;
				end
				tdq_pkg::ACT_COMPLETE: begin
					if (status.busy) begin
						if (!status.empty) cmd.launch_queued = 1'b1;
						else cmd.go_idle = 1'b1;
					end
				end
				tdq_pkg::ACT_READ_CLEAR: begin
					cmd.clear_bitmap = 1'b1;
				end
				default: begin
					// unused code, status report only
				end
			endcase
		end
	end

endmodule

>>> sv/tdq_datapath.sv
`timescale 1ns / 1ps

module tdq_datapath #(
	parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input tdq_pkg::dp_cmd_t cmd,
	output tdq_pkg::dp_status_t status,
	input tdq_pkg::req_word_t req_word,
	output tdq_pkg::rsp_word_t rsp_word
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SAT_W = (FILL_W > tdq_pkg::CNT_W) ? FILL_W : tdq_pkg::CNT_W;

	tdq_pkg::req_word_t req_q;
	tdq_pkg::rsp_word_t rsp_q;
	tdq_pkg::desc_t mem_q [QUEUE_DEPTH];
	tdq_pkg::desc_t rd_data_q;
	logic busy_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [tdq_pkg::BITMAP_BITS-1:0] bitmap_q;

	tdq_pkg::desc_t req_desc;
	tdq_pkg::desc_t launch_desc;
	tdq_pkg::rsp_word_t rsp_next;
	logic launch;
	logic busy_next;
	logic [FILL_W-1:0] fill_next;
	logic [SAT_W-1:0] fill_ext;
	logic [tdq_pkg::BITMAP_BITS-1:0] bitmap_next;
	logic [PTR_W-1:0] rd_ptr_next;
	logic [PTR_W-1:0] wr_ptr_next;

	always_comb begin
		req_desc.channel = req_q.req_channel;
		req_desc.address = req_q.req_address;
		req_desc.length = req_q.req_length;

		launch = cmd.launch_new | cmd.launch_queued;
		launch_desc = cmd.launch_queued ? rd_data_q : req_desc;

		// a launch marks its channel, wide channels mark nothing; a read-clear empties the bitmap
		bitmap_next = bitmap_q;
		if (launch && (launch_desc.channel < tdq_pkg::CH_W'(tdq_pkg::BITMAP_BITS))) begin
			bitmap_next[launch_desc.channel[tdq_pkg::BIT_IDX_W-1:0]] = 1'b1;
		end
		if (cmd.clear_bitmap) bitmap_next = '0;

		busy_next = launch ? 1'b1 : (cmd.go_idle ? 1'b0 : busy_q);

		fill_next = fill_q;
		if (cmd.push) fill_next = fill_q + 1'b1;
		else if (cmd.launch_queued) fill_next = fill_q - 1'b1;
		fill_ext = SAT_W'(fill_next);

		rd_ptr_next = rd_ptr_q;
		if (cmd.launch_queued) begin
			rd_ptr_next = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
		wr_ptr_next = wr_ptr_q;
		if (cmd.push) begin
			wr_ptr_next = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		end

		rsp_next = '0;
		rsp_next.launched = launch;
		if (launch) begin
			rsp_next.launch_channel = launch_desc.channel;
			rsp_next.launch_address = launch_desc.address;
			rsp_next.launch_length = launch_desc.length;
		end
		rsp_next.dropped = cmd.drop;
		rsp_next.engine_busy = busy_next;
		rsp_next.waiting_count = (fill_ext > SAT_W'(tdq_pkg::CNT_MAX))
			? tdq_pkg::CNT_W'(tdq_pkg::CNT_MAX) : fill_ext[tdq_pkg::CNT_W-1:0];
		rsp_next.bitmap_value = cmd.clear_bitmap ? bitmap_q : bitmap_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q <= '0;
			bitmap_q <= '0;
		end else begin
			busy_q <= busy_next;
			rd_ptr_q <= rd_ptr_next;
			wr_ptr_q <= wr_ptr_next;
			fill_q <= fill_next;
			bitmap_q <= bitmap_next;
		end
	end

	// payload registers and descriptor memory
	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req_word;
		if (cmd.load_out) rsp_q <= rsp_next;
		if (cmd.push) mem_q[wr_ptr_q] <= req_desc;
		rd_data_q <= mem_q[rd_ptr_q];
	end

	assign status.busy = busy_q;
	assign status.full = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);
	assign status.action = req_q.action;
	assign rsp_word = rsp_q;

endmodule

>>> sv/transfer_descriptor_queue_unit.sv
`timescale 1ns / 1ps
// result: a result word is valid once the controller has passed its execute state
// sequencing: the controller handles one word at a time (capture, execute, hold
//   result) and takes no new request word until the result has been taken
// reset: arst_n clears busy flag, pointers, fill count, bitmap and controller;
//   the descriptor memory is not cleared, the fill count guards every read

module transfer_descriptor_queue_unit #(
	parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	tdq_chan_if.sink request,
	tdq_chan_if.source result
);

	// command and status between controller and datapath
	tdq_pkg::dp_cmd_t cmd;
	tdq_pkg::dp_status_t status;

	// payload views of the two channels
	tdq_pkg::req_word_t req_word;
	tdq_pkg::rsp_word_t rsp_word;

	assign req_word = request.data;
	assign result.data = rsp_word;

	// sequencer: idle -> execute -> hold result until taken
	tdq_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.rsp_valid (result.valid),
		.rsp_ready (result.ready),
		.status (status),
		.cmd (cmd)
	);

	// descriptor fifo, busy flag, launch bitmap and result register
	tdq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (cmd),
		.status (status),
		.req_word (req_word),
		.rsp_word (rsp_word)
	);

endmodule

>>> tb/sv/transfer_descriptor_queue_unit_test.sv
`timescale 1ns / 1ps

module transfer_descriptor_queue_unit_test;
	import tdq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	// action value with no meaning, the block reports status only
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 10;

	// one row of the directed plan; typed rows carry a hand-written result
	typedef struct {
		req_word_t req;
		bit typed;
		rsp_word_t rsp;
	} plan_row_t;

	logic clk;
	logic arst_n;

	tdq_chan_if #(.word_t(req_word_t)) request_ch ();
	tdq_chan_if #(.word_t(rsp_word_t)) result_ch ();

	transfer_descriptor_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.result(result_ch)
	);

	// shadow copy of the queue state
	bit engine_on;
	desc_t shadow_store [DEPTH];
	int rd_idx;
	int wr_idx;
	int fill;
	logic [BITMAP_BITS-1:0] launch_bitmap;

	// results still owed by the block, oldest first
	rsp_word_t awaited_results [$];
	plan_row_t directed_plan [$];

	// control shared between the sender and the receiver
	bit steady_flow;
	bit results_hold_req;

	int errors;
	int words_sent;
	int results_seen;
	int n_launch;
	int n_queued;
	int n_dropped;
	int n_idle_complete;
	int n_wide_launch;
	int n_read_clear;
	int peak_fill;

	// clock, 10 ns period
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset held at the start, released once
	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// generous cap on the whole run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic req_word_t req_of(input logic [ACTION_W-1:0] act,
		input logic [CH_W-1:0] ch, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] len);
		req_word_t w;
		w.action = act;
		w.req_channel = ch;
		w.req_address = addr;
		w.req_length = len;
		return w;
	endfunction

	function automatic rsp_word_t rsp_of(input logic launched, input logic [CH_W-1:0] ch,
		input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len, input logic dropped,
		input logic busy, input logic [CNT_W-1:0] waiting, input logic [BITMAP_BITS-1:0] bmp);
		rsp_word_t r;
		r.launched = launched;
		r.launch_channel = ch;
		r.launch_address = addr;
		r.launch_length = len;
		r.dropped = dropped;
		r.engine_busy = busy;
		r.waiting_count = waiting;
		r.bitmap_value = bmp;
		return r;
	endfunction

	// start the engine on a descriptor and mark its channel
	function automatic void start_engine(inout rsp_word_t r, input desc_t d);
		engine_on = 1'b1;
		if (d.channel < BITMAP_BITS) begin
			launch_bitmap[d.channel[BIT_IDX_W-1:0]] = 1'b1;
		end else begin
			n_wide_launch++;
		end
		r.launched = 1'b1;
		r.launch_channel = d.channel;
		r.launch_address = d.address;
		r.launch_length = d.length;
		n_launch++;
	endfunction

	// next queue status for one request word; updates the shadow state
	function automatic rsp_word_t queue_outcome(input req_word_t w);
		rsp_word_t r;
		desc_t d;
		logic [BITMAP_BITS-1:0] bmp_report;
		r = '0;
		d.channel = w.req_channel;
		d.address = w.req_address;
		d.length = w.req_length;
		case (w.action)
			ACT_ENQUEUE: begin
				if (!engine_on) begin
					start_engine(r, d);
				end else if (fill >= DEPTH) begin
					r.dropped = 1'b1;
					n_dropped++;
				end else begin
					shadow_store[wr_idx] = d;
					wr_idx = (wr_idx == DEPTH - 1) ? 0 : wr_idx + 1;
					fill++;
					n_queued++;
				end
				bmp_report = launch_bitmap;
			end
			ACT_COMPLETE: begin
				if (engine_on) begin
					if (fill > 0) begin
						d = shadow_store[rd_idx];
						rd_idx = (rd_idx == DEPTH - 1) ? 0 : rd_idx + 1;
						fill--;
						start_engine(r, d);
					end else begin
						engine_on = 1'b0;
					end
				end else begin
					n_idle_complete++;
				end
				bmp_report = launch_bitmap;
			end
			ACT_READ_CLEAR: begin
				bmp_report = launch_bitmap;
				launch_bitmap = '0;
				n_read_clear++;
			end
			default: begin
				bmp_report = launch_bitmap;
			end
		endcase
		if (fill > peak_fill) peak_fill = fill;
		r.engine_busy = engine_on;
		r.waiting_count = (fill > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : fill[CNT_W-1:0];
		r.bitmap_value = bmp_report;
		return r;
	endfunction

	// offer one word until accepted, then log what it must produce
	task automatic push_request(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
		rsp_word_t predicted;
		if (!steady_flow) begin
			while ($urandom_range(99) < 30) begin
				request_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		request_ch.valid <= 1'b1;
		request_ch.data <= w;
		do @(posedge clk); while (!request_ch.ready);
		// shadow state moves on either way; typed rows check the block directly
		predicted = queue_outcome(w);
		awaited_results.push_back(typed ? typed_rsp : predicted);
		words_sent++;
	endtask

	// random content; channels lean toward the bitmap range and its edges
	function automatic req_word_t random_req(input logic [ACTION_W-1:0] act);
		int pick;
		logic [CH_W-1:0] ch;
		pick = $urandom_range(99);
		if (pick < 40) ch = 8'($urandom_range(255));
		else if (pick < 80) ch = 8'($urandom_range(BITMAP_BITS - 1));
		else case ($urandom_range(3))
			0: ch = 8'd0;
			1: ch = 8'(BITMAP_BITS - 1);
			2: ch = 8'(BITMAP_BITS);
			default: ch = 8'hff;
		endcase
		return req_of(act, ch, $urandom, 16'($urandom_range(65535)));
	endfunction

	function automatic logic [ACTION_W-1:0] mixed_action();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) return ACT_ENQUEUE;
		if (pick < 90) return ACT_COMPLETE;
		if (pick < 98) return ACT_READ_CLEAR;
		return ACT_UNUSED;
	endfunction

	// unused action words are sent and checked but not counted
	task automatic issue_random(input logic [ACTION_W-1:0] act, inout int counted);
		push_request(random_req(act), 1'b0, '0);
		if (act != ACT_UNUSED) counted++;
	endtask

	// hold the sender back until the block owes nothing
	task automatic wait_drained();
		request_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input req_word_t w, input bit typed, input rsp_word_t r);
		plan_row_t row;
		row.req = w;
		row.typed = typed;
		row.rsp = r;
		directed_plan.push_back(row);
	endtask

	task automatic compare_field(input string fname, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, fname, want, got);
		end
	endtask

	// result side: ready drops with a chance of about 30 in 100 unless the flow is steady, with one long hold-off
	initial begin
		bit hold_taken;
		hold_taken = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_hold_req && !hold_taken) begin
				result_ch.ready <= 1'b0;
				hold_taken = 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				result_ch.ready <= arst_n && (steady_flow || $urandom_range(99) >= 30);
			end
		end
	end

	// compare every accepted result word with the oldest one owed
	always @(posedge clk) begin
		rsp_word_t want;
		rsp_word_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			results_seen++;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t ns: result word with none owed, actual 0x%0h", $time, got);
			end else begin
				want = awaited_results.pop_front();
				compare_field("launched", 64'(want.launched), 64'(got.launched));
				compare_field("launch_channel", 64'(want.launch_channel),
					64'(got.launch_channel));
				compare_field("launch_address", 64'(want.launch_address),
					64'(got.launch_address));
				compare_field("launch_length", 64'(want.launch_length),
					64'(got.launch_length));
				compare_field("dropped", 64'(want.dropped), 64'(got.dropped));
				compare_field("engine_busy", 64'(want.engine_busy), 64'(got.engine_busy));
				compare_field("waiting_count", 64'(want.waiting_count),
					64'(got.waiting_count));
				compare_field("bitmap_value", 64'(want.bitmap_value), 64'(got.bitmap_value));
			end
		end
	end

	// request side: directed rows, then random segments
	initial begin
		int random_sent;
		int drain_cycles;
		bit hold_done;
		bit pause_done;
		bit steady_done;
		int seg_len;
		request_ch.valid <= 1'b0;
		request_ch.data <= '0;
		engine_on = 1'b0;
		rd_idx = 0;
		wr_idx = 0;
		fill = 0;
		launch_bitmap = '0;
		steady_flow = 1'b0;
		results_hold_req = 1'b0;
		random_sent = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		steady_done = 1'b0;

		// fresh out of reset: completion while idle, empty bitmap, unused action
		add_row(req_of(ACT_COMPLETE, 8'd0, 32'd0, 16'd0), 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(req_of(ACT_READ_CLEAR, 8'hff, 32'hffff_ffff, 16'hffff), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(req_of(ACT_UNUSED, 8'hff, 32'hffff_ffff, 16'hffff), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 0, 0, 0));
		// idle engine launches at once, all-zero fields
		add_row(req_of(ACT_ENQUEUE, 8'd0, 32'd0, 16'd0), 1'b1,
			rsp_of(1, 0, 0, 0, 0, 1, 0, 32'h1));
		// busy engine: all-ones, bitmap top bit, first wide channel wait in line
		add_row(req_of(ACT_ENQUEUE, 8'hff, 32'hffff_ffff, 16'hffff), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 1, 1, 32'h1));
		add_row(req_of(ACT_ENQUEUE, 8'd31, 32'ha5a5_a5a5, 16'h5a5a), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 1, 2, 32'h1));
		add_row(req_of(ACT_ENQUEUE, 8'd32, 32'h5a5a_5a5a, 16'ha5a5), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 1, 3, 32'h1));
		add_row(req_of(ACT_UNUSED, 8'd0, 32'd0, 16'd0), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 1, 3, 32'h1));
		// completions launch in arrival order; wide channels leave no mark
		add_row(req_of(ACT_COMPLETE, 8'h5a, 32'h1234_5678, 16'h9abc), 1'b1,
			rsp_of(1, 8'hff, 32'hffff_ffff, 16'hffff, 0, 1, 2, 32'h1));
		add_row(req_of(ACT_COMPLETE, 8'd0, 32'd0, 16'd0), 1'b1,
			rsp_of(1, 8'd31, 32'ha5a5_a5a5, 16'h5a5a, 0, 1, 1, 32'h8000_0001));
		add_row(req_of(ACT_READ_CLEAR, 8'h12, 32'hdead_beef, 16'h3456), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 1, 1, 32'h8000_0001));
		add_row(req_of(ACT_COMPLETE, 8'd0, 32'd0, 16'd0), 1'b1,
			rsp_of(1, 8'd32, 32'h5a5a_5a5a, 16'ha5a5, 0, 1, 0, 32'h0));
		// last completion with nothing waiting goes idle, the next one is a no-op
		add_row(req_of(ACT_COMPLETE, 8'd0, 32'd0, 16'd0), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(req_of(ACT_COMPLETE, 8'hff, 32'hffff_ffff, 16'hffff), 1'b1,
			rsp_of(0, 0, 0, 0, 0, 0, 0, 0));
		// rows left to the shadow model
		add_row(req_of(ACT_ENQUEUE, 8'd7, 32'h0000_1000, 16'd1), 1'b0, '0);
		add_row(req_of(ACT_ENQUEUE, 8'd16, 32'h8000_0000, 16'h8000), 1'b0, '0);
		add_row(req_of(ACT_ENQUEUE, 8'd128, 32'h0000_0001, 16'h0001), 1'b0, '0);
		add_row(req_of(ACT_READ_CLEAR, 8'd0, 32'd0, 16'd0), 1'b0, '0);
		add_row(req_of(ACT_COMPLETE, 8'd0, 32'd0, 16'd0), 1'b0, '0);
		add_row(req_of(ACT_COMPLETE, 8'd0, 32'd0, 16'd0), 1'b0, '0);
		add_row(req_of(ACT_READ_CLEAR, 8'd0, 32'd0, 16'd0), 1'b0, '0);

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (directed_plan[i])
			push_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].rsp);

		// sender pause: let every owed result come back
		wait_drained();

		while (random_sent < RANDOM_WORDS) begin
			if (!hold_done && random_sent >= 300) begin
				// results held off while requests keep coming: the block backs up,
				// and a run of enqueues past the depth forces drops
				hold_done = 1'b1;
				results_hold_req = 1'b1;
				repeat (DEPTH + 9) issue_random(ACT_ENQUEUE, random_sent);
				repeat (DEPTH + 4) issue_random(ACT_COMPLETE, random_sent);
			end else if (!pause_done && random_sent >= 550) begin
				pause_done = 1'b1;
				wait_drained();
			end else if (!steady_done && random_sent >= 700) begin
				// stretch with no idling on either side
				steady_done = 1'b1;
				steady_flow = 1'b1;
				repeat (150) issue_random(mixed_action(), random_sent);
				steady_flow = 1'b0;
			end else begin
				seg_len = $urandom_range(1, 40);
				case ($urandom_range(9))
					0, 1, 2: repeat (seg_len) issue_random(ACT_ENQUEUE, random_sent);
					3, 4: repeat (seg_len) issue_random(ACT_COMPLETE, random_sent);
					5, 6, 7, 8: repeat (seg_len / 2 + 1) issue_random(mixed_action(), random_sent);
					default: issue_random(ACT_READ_CLEAR, random_sent);
				endcase
			end
		end
		request_ch.valid <= 1'b0;

		// drain, bounded
		drain_cycles = 0;
		while (awaited_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t ns: %0d result words never arrived", $time, awaited_results.size());
		end

		$display("run: %0d request words, %0d results; %0d launches, %0d queued, %0d dropped",
			words_sent, results_seen, n_launch, n_queued, n_dropped);
		$display("run: %0d idle completions, %0d wide-channel launches, %0d bitmap reads,",
			n_idle_complete, n_wide_launch, n_read_clear, " peak fill %0d", peak_fill);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> transfer_descriptor_queue_unit.f
sv/tdq_pkg.sv
sv/tdq_chan_if.sv
sv/tdq_ctrl.sv
sv/tdq_datapath.sv
sv/transfer_descriptor_queue_unit.sv
tb/sv/transfer_descriptor_queue_unit_test.sv
